/* hw/rtl/jap_pkg.sv */
// Shared types, widths and constants for the joystick correction pipeline.
package jap_pkg;

   // fixed datapath widths
   localparam int COEF_W       = 32;
   localparam int XS_W         = 32;
   localparam int SQ_W         = 64;
   localparam int R_W          = 32;
   localparam int CX_W         = 35;
   localparam int Z_W          = 26;
   localparam int OUT_W        = 16;
   localparam int QUO_BITS     = 15;
   localparam int DIV_W        = 47;
   localparam int SQRT_STAGES  = 32;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_W       = 22;
   localparam int REG_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // rounding and scaling constants
   localparam int ROUND_SHIFT  = 14;
   localparam int ROUND_BIAS   = 8192;
   localparam int UNIT_SHIFT   = 14;
   localparam int DIR_SHIFT    = 8;
   localparam int DIR_BIAS     = 128;
   localparam int SQ_BIT_TOP   = 62;
   localparam longint XS_LIMIT = 64'sd2147483647;
   localparam logic [SQ_W-1:0] UNIT_SQ = 64'h0000_0001_0000_0000;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd4194304;
   localparam logic [OUT_W-1:0] MAG_ONE = 16'd32768;
   localparam logic signed [COEF_W-1:0] COEF_DIAG_RESET = 32'sd524288;

   // arctangent of 2^-i in units of pi/2^23
   localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
      22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
      22'd10,      22'd5,       22'd3,      22'd1,      22'd1,      22'd0
   };

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_COEF_XX  = 3'd2,
      REG_COEF_XY  = 3'd3,
      REG_COEF_YX  = 3'd4,
      REG_COEF_YY  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [REG_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } csr_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos_x;
      logic signed [OUT_W-1:0] pos_y;
      logic [OUT_W-1:0]        magnitude;
      logic signed [OUT_W-1:0] direction;
      logic                    clamped;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] xx;
      logic signed [COEF_W-1:0] xy;
      logic signed [COEF_W-1:0] yx;
      logic signed [COEF_W-1:0] yy;
   } coef_type;

   // corrected vector, Q.16
   typedef struct packed {
      logic signed [XS_W-1:0] xs;
      logic signed [XS_W-1:0] ys;
   } xy_type;

   // radius and angle results handed to the scaler
   typedef struct packed {
      logic signed [XS_W-1:0] xs;
      logic signed [XS_W-1:0] ys;
      logic [R_W-1:0]         r;
      logic signed [Z_W-1:0]  z;
      logic                   clamped;
      logic                   zero;
   } polar_type;

endpackage

/* hw/rtl/jap_intf.sv */
// Stream and register-write interfaces of the joystick correction core.
interface jap_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] raw_x;
   logic [ADC_BITS-1:0] raw_y;
   modport source (output valid, output raw_x, output raw_y, input ready);
   modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface jap_rsp_if;
   import jap_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface jap_csr_if;
   import jap_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/jap_csr.sv */
// Configuration registers: center point and correction matrix.
module jap_csr #(
   parameter int ADC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   jap_csr_if.sink             csr_if,
   output logic [ADC_BITS-1:0] center_x,
   output logic [ADC_BITS-1:0] center_y,
   output jap_pkg::coef_type   coef
);
   import jap_pkg::*;

   localparam logic [ADC_BITS-1:0] CENTER_RESET = {1'b1, {(ADC_BITS-1){1'b0}}};

   logic [ADC_BITS-1:0] center_x_ff;
   logic [ADC_BITS-1:0] center_y_ff;
   coef_type            coef_ff;

   // always take a write word
   assign csr_if.ready = 1'b1;

   // decode the index, drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_RESET;
         center_y_ff <= CENTER_RESET;
         coef_ff.xx  <= COEF_DIAG_RESET;
         coef_ff.xy  <= '0;
         coef_ff.yx  <= '0;
         coef_ff.yy  <= COEF_DIAG_RESET;
      end else if (csr_if.valid) begin
         case (reg_index_type'(csr_if.data.index))
            REG_CENTER_X: center_x_ff <= csr_if.data.value[ADC_BITS-1:0];
            REG_CENTER_Y: center_y_ff <= csr_if.data.value[ADC_BITS-1:0];
            REG_COEF_XX:  coef_ff.xx  <= $signed(csr_if.data.value);
            REG_COEF_XY:  coef_ff.xy  <= $signed(csr_if.data.value);
            REG_COEF_YX:  coef_ff.yx  <= $signed(csr_if.data.value);
            REG_COEF_YY:  coef_ff.yy  <= $signed(csr_if.data.value);
            default: ;
         endcase
      end
   end

   assign center_x = center_x_ff;
   assign center_y = center_y_ff;
   assign coef     = coef_ff;

endmodule

/* hw/rtl/jap_affine.sv */
// Center subtract, 2x2 matrix multiply, round and saturate to Q.16.
module jap_affine #(
   parameter int ADC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [ADC_BITS-1:0] raw_x,
   input  logic [ADC_BITS-1:0] raw_y,
   input  logic [ADC_BITS-1:0] center_x,
   input  logic [ADC_BITS-1:0] center_y,
   input  jap_pkg::coef_type   coef,
   output logic                out_valid,
   output jap_pkg::xy_type     out_word
);
   import jap_pkg::*;

   localparam int D_W    = ADC_BITS + 1;
   localparam int PROD_W = COEF_W + D_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int STAGES = 4;
   localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(XS_LIMIT);
   localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;
   localparam logic signed [SUM_W-1:0] RND     = SUM_W'(ROUND_BIAS);

   logic [STAGES-1:0]        v_ff;
   logic signed [D_W-1:0]    dx_ff, dy_ff;
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [SUM_W-1:0]  ax_ff, ay_ff;
   xy_type                   xy_ff;

   function automatic logic signed [XS_W-1:0] round_sat(input logic signed [SUM_W-1:0] a);
      logic signed [SUM_W-1:0] t;
      t = (a + RND) >>> ROUND_SHIFT;
      if (t > LIM_POS)
         t = LIM_POS;
      else if (t < LIM_NEG)
         t = LIM_NEG;
      return t[XS_W-1:0];
   endfunction

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   // offsets, products, sums, rounding
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= $signed({1'b0, raw_x}) - $signed({1'b0, center_x});
         dy_ff  <= $signed({1'b0, raw_y}) - $signed({1'b0, center_y});
         pxx_ff <= PROD_W'(coef.xx) * PROD_W'(dx_ff);
         pxy_ff <= PROD_W'(coef.xy) * PROD_W'(dy_ff);
         pyx_ff <= PROD_W'(coef.yx) * PROD_W'(dx_ff);
         pyy_ff <= PROD_W'(coef.yy) * PROD_W'(dy_ff);
         ax_ff  <= SUM_W'(pxx_ff) + SUM_W'(pxy_ff);
         ay_ff  <= SUM_W'(pyx_ff) + SUM_W'(pyy_ff);
         xy_ff.xs <= round_sat(ax_ff);
         xy_ff.ys <= round_sat(ay_ff);
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_word  = xy_ff;

endmodule

/* hw/rtl/jap_polar.sv */
// Sum of squares, pipelined square root and vectoring CORDIC in lockstep.
module jap_polar #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  jap_pkg::xy_type    in_word,
   output logic               out_valid,
   output jap_pkg::polar_type out_word
);
   import jap_pkg::*;

   localparam int PRE    = 3;
   localparam int VLEN   = PRE + SQRT_STAGES;
   localparam int MAG_W  = XS_W - 1;
   localparam int SQR_W  = 2 * MAG_W;

   typedef struct packed {
      logic signed [XS_W-1:0] xs;
      logic signed [XS_W-1:0] ys;
      logic [MAG_W-1:0]       ux;
      logic [MAG_W-1:0]       uy;
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } fold_type;

   typedef struct packed {
      logic [SQR_W-1:0]       sqx;
      logic [SQR_W-1:0]       sqy;
      logic signed [XS_W-1:0] xs;
      logic signed [XS_W-1:0] ys;
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } sq_type;

   typedef struct packed {
      logic [SQ_W-1:0]        n;
      logic [SQ_W-1:0]        res;
      logic signed [XS_W-1:0] xs;
      logic signed [XS_W-1:0] ys;
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [Z_W-1:0]  z;
      logic                   clamped;
      logic                   zero;
   } sc_type;

   logic [VLEN-1:0] v_ff;
   fold_type        fold_ff, fold_in;
   sq_type          sq_ff;
   sc_type          st_ff [SQRT_STAGES+1];

   // magnitudes and quarter-turn fold into the right half plane
   always_comb begin
      logic [XS_W-1:0]        ax, ay;
      logic signed [CX_W-1:0] ex, ey;
      ax = in_word.xs[XS_W-1] ? -in_word.xs : in_word.xs;
      ay = in_word.ys[XS_W-1] ? -in_word.ys : in_word.ys;
      ex = CX_W'(in_word.xs);
      ey = CX_W'(in_word.ys);
      fold_in.xs   = in_word.xs;
      fold_in.ys   = in_word.ys;
      fold_in.ux   = ax[MAG_W-1:0];
      fold_in.uy   = ay[MAG_W-1:0];
      fold_in.zero = (in_word.xs == '0) && (in_word.ys == '0);
      if (!in_word.xs[XS_W-1]) begin
         fold_in.cx = ex;
         fold_in.cy = ey;
         fold_in.z  = '0;
      end else if (!in_word.ys[XS_W-1]) begin
         fold_in.cx = ey;
         fold_in.cy = -ex;
         fold_in.z  = QUARTER_TURN;
      end else begin
         fold_in.cx = -ey;
         fold_in.cy = ex;
         fold_in.z  = -QUARTER_TURN;
      end
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[VLEN-2:0], in_valid};
      end
   end

   // fold, square, sum and clamp test
   always_ff @(posedge clock) begin
      if (adv) begin
         fold_ff     <= fold_in;
         sq_ff.sqx   <= SQR_W'(fold_ff.ux) * SQR_W'(fold_ff.ux);
         sq_ff.sqy   <= SQR_W'(fold_ff.uy) * SQR_W'(fold_ff.uy);
         sq_ff.xs    <= fold_ff.xs;
         sq_ff.ys    <= fold_ff.ys;
         sq_ff.cx    <= fold_ff.cx;
         sq_ff.cy    <= fold_ff.cy;
         sq_ff.z     <= fold_ff.z;
         sq_ff.zero  <= fold_ff.zero;
         st_ff[0].n       <= SQ_W'(sq_ff.sqx) + SQ_W'(sq_ff.sqy);
         st_ff[0].res     <= '0;
         st_ff[0].xs      <= sq_ff.xs;
         st_ff[0].ys      <= sq_ff.ys;
         st_ff[0].cx      <= sq_ff.cx;
         st_ff[0].cy      <= sq_ff.cy;
         st_ff[0].z       <= sq_ff.z;
         st_ff[0].clamped <= (SQ_W'(sq_ff.sqx) + SQ_W'(sq_ff.sqy)) > UNIT_SQ;
         st_ff[0].zero    <= sq_ff.zero;
      end
   end

   // one root bit per stage; one rotation per stage below both CORDIC_STAGES and ATAN_ENTRIES
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_BIT_TOP - 2 * k);
      sc_type                 nxt;
      logic signed [CX_W-1:0] cx_n, cy_n;
      logic signed [Z_W-1:0]  z_n;

      if (k < CORDIC_STAGES && k < ATAN_ENTRIES) begin : g_rot
         always_comb begin
            logic signed [CX_W-1:0] xsh, ysh;
            xsh = st_ff[k].cx >>> k;
            ysh = st_ff[k].cy >>> k;
            if (!st_ff[k].cy[CX_W-1]) begin
               cx_n = st_ff[k].cx + ysh;
               cy_n = st_ff[k].cy - xsh;
               z_n  = st_ff[k].z + Z_W'(ATAN_TAB[k]);
            end else begin
               cx_n = st_ff[k].cx - ysh;
               cy_n = st_ff[k].cy + xsh;
               z_n  = st_ff[k].z - Z_W'(ATAN_TAB[k]);
            end
         end
      end else begin : g_hold
         assign cx_n = st_ff[k].cx;
         assign cy_n = st_ff[k].cy;
         assign z_n  = st_ff[k].z;
      end

      always_comb begin
         logic [SQ_W-1:0] trial;
         nxt   = st_ff[k];
         trial = st_ff[k].res + BIT;
         if (st_ff[k].n >= trial) begin
            nxt.n   = st_ff[k].n - trial;
            nxt.res = (st_ff[k].res >> 1) + BIT;
         end else begin
            nxt.res = st_ff[k].res >> 1;
         end
         nxt.cx = cx_n;
         nxt.cy = cy_n;
         nxt.z  = z_n;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k+1] <= nxt;
         end
      end
   end

   assign out_valid        = v_ff[VLEN-1];
   assign out_word.xs      = st_ff[SQRT_STAGES].xs;
   assign out_word.ys      = st_ff[SQRT_STAGES].ys;
   assign out_word.r       = st_ff[SQRT_STAGES].res[R_W-1:0];
   assign out_word.z       = st_ff[SQRT_STAGES].z;
   assign out_word.clamped = st_ff[SQRT_STAGES].clamped;
   assign out_word.zero    = st_ff[SQRT_STAGES].zero;

endmodule

/* hw/rtl/jap_scale.sv */
// Unit-circle scaling by restoring division and output word assembly.
module jap_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  jap_pkg::polar_type    in_word,
   output logic                  out_valid,
   output jap_pkg::rsp_word_type out_word
);
   import jap_pkg::*;

   localparam int VLEN = QUO_BITS + 2;

   typedef struct packed {
      logic [DIV_W-1:0]    rem_x;
      logic [DIV_W-1:0]    rem_y;
      logic [R_W-1:0]      dvs;
      logic [QUO_BITS-1:0] q_x;
      logic [QUO_BITS-1:0] q_y;
      logic                neg_x;
      logic                neg_y;
      rsp_word_type        word;
   } div_type;

   logic [VLEN-1:0] v_ff;
   div_type         d_in;
   div_type         st_ff [QUO_BITS+1];
   rsp_word_type    fin_ff, fin_in;

   // numerators and the unclamped result fields
   always_comb begin
      logic [XS_W-1:0]        ux, uy;
      logic signed [XS_W:0]   px, py;
      logic [R_W:0]           m;
      logic signed [Z_W-1:0]  zt;
      ux = in_word.xs[XS_W-1] ? -in_word.xs : in_word.xs;
      uy = in_word.ys[XS_W-1] ? -in_word.ys : in_word.ys;
      px = (($signed({in_word.xs[XS_W-1], in_word.xs}) + 33'sd2) >>> 2);
      py = (($signed({in_word.ys[XS_W-1], in_word.ys}) + 33'sd2) >>> 2);
      m  = {1'b0, in_word.r} + {{R_W{1'b0}}, 1'b1};
      zt = (in_word.z + Z_W'(DIR_BIAS)) >>> DIR_SHIFT;
      d_in.rem_x = (DIV_W'(ux) << UNIT_SHIFT) + DIV_W'(in_word.r >> 1);
      d_in.rem_y = (DIV_W'(uy) << UNIT_SHIFT) + DIV_W'(in_word.r >> 1);
      d_in.dvs   = in_word.r;
      d_in.q_x   = '0;
      d_in.q_y   = '0;
      d_in.neg_x = in_word.xs[XS_W-1];
      d_in.neg_y = in_word.ys[XS_W-1];
      d_in.word.pos_x     = px[OUT_W-1:0];
      d_in.word.pos_y     = py[OUT_W-1:0];
      d_in.word.magnitude = m[OUT_W:1];
      d_in.word.direction = in_word.zero ? '0 : zt[OUT_W-1:0];
      d_in.word.clamped   = in_word.clamped;
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[VLEN-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= d_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      localparam int SH = QUO_BITS - 1 - i;
      div_type nxt;

      always_comb begin
         logic [DIV_W-1:0] dsh;
         nxt = st_ff[i];
         dsh = DIV_W'(st_ff[i].dvs) << SH;
         if (st_ff[i].rem_x >= dsh) begin
            nxt.rem_x   = st_ff[i].rem_x - dsh;
            nxt.q_x[SH] = 1'b1;
         end
         if (st_ff[i].rem_y >= dsh) begin
            nxt.rem_y   = st_ff[i].rem_y - dsh;
            nxt.q_y[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[i+1] <= nxt;
         end
      end
   end

   // pick clamped or direct fields
   always_comb begin
      logic [OUT_W-1:0] qx, qy;
      qx     = OUT_W'(st_ff[QUO_BITS].q_x);
      qy     = OUT_W'(st_ff[QUO_BITS].q_y);
      fin_in = st_ff[QUO_BITS].word;
      if (st_ff[QUO_BITS].word.clamped) begin
         fin_in.pos_x     = st_ff[QUO_BITS].neg_x ? -qx : qx;
         fin_in.pos_y     = st_ff[QUO_BITS].neg_y ? -qy : qy;
         fin_in.magnitude = MAG_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   assign out_valid = v_ff[VLEN-1];
   assign out_word  = fin_ff;

endmodule

/* hw/rtl/joystick_affine_polar_correct_core.sv */
// Top level of the joystick affine correction and polar conversion core.
//
//   channel   dir   words carried
//   req_if    in    raw_x, raw_y sample pair
//   rsp_if    out   pos_x, pos_y, magnitude, direction, clamped
//   csr_if    in    register index and write data
//
// One sample pair enters per cycle while the output queue is not full; each result
// passes through the 32-stage square root and the 15-stage divider.
// Reset clears valid bits, the output queue and the registers to defaults.
// A two-word output queue lets the pipeline keep taking words while a result
// waits; the pipeline holds only when both queue slots are full.
module joystick_affine_polar_correct_core #(
   parameter int ADC_BITS      = 12,
   parameter int CORDIC_STAGES = 16
) (
   input logic        clock,
   input logic        reset,
   jap_req_if.sink    req_if,
   jap_rsp_if.source  rsp_if,
   jap_csr_if.sink    csr_if
);
   import jap_pkg::*;

   localparam int BUF_DEPTH = 2;

   logic [ADC_BITS-1:0] center_x, center_y;
   coef_type            coef;
   logic                adv;
   logic                xy_valid, polar_valid, fin_valid;
   xy_type              xy_word;
   polar_type           polar_word;
   rsp_word_type        fin_word;

   rsp_word_type        buf_ff [BUF_DEPTH];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   jap_csr #(.ADC_BITS(ADC_BITS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_if   (csr_if),
      .center_x (center_x),
      .center_y (center_y),
      .coef     (coef)
   );

   jap_affine #(.ADC_BITS(ADC_BITS)) u_affine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_if.valid),
      .raw_x     (req_if.raw_x),
      .raw_y     (req_if.raw_y),
      .center_x  (center_x),
      .center_y  (center_y),
      .coef      (coef),
      .out_valid (xy_valid),
      .out_word  (xy_word)
   );

   jap_polar #(.CORDIC_STAGES(CORDIC_STAGES)) u_polar (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (xy_valid),
      .in_word   (xy_word),
      .out_valid (polar_valid),
      .out_word  (polar_word)
   );

   jap_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (polar_valid),
      .in_word   (polar_word),
      .out_valid (fin_valid),
      .out_word  (fin_word)
   );

   // hold the pipeline only when the output queue is full
   assign adv          = (count_ff != 2'(BUF_DEPTH));
   assign req_if.ready = adv;
   assign push         = adv && fin_valid;
   assign pop          = rsp_if.valid && rsp_if.ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= fin_word;
      end
   end

   assign rsp_if.valid = (count_ff != 2'd0);
   assign rsp_if.data  = buf_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(BUF_DEPTH))
      else $error("output queue count out of range");

   a_clamp_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.clamped |-> rsp_if.data.magnitude == MAG_ONE)
      else $error("clamped word without unit magnitude");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.data.pos_x <= 16'sd16384 && rsp_if.data.pos_x >= -16'sd16384
                        && rsp_if.data.magnitude <= MAG_ONE))
      else $error("corrected position outside unit range");
`endif

endmodule
